>>> rtl/deadline_timer_event_queue_unit_defines.svh
// Assertion macros for the deadline timer event queue.
`ifndef DEADLINE_TIMER_EVENT_QUEUE_UNIT_DEFINES_SVH
`define DEADLINE_TIMER_EVENT_QUEUE_UNIT_DEFINES_SVH
`ifndef SYNTH
`define DTQ_ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: check failed");
`define DTQ_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m: check failed");
`else
`define DTQ_ASSERT_IMPL(label, clk, rst, prop)
`define DTQ_ASSERT_NORST(label, clk, prop)
`endif
`endif

>>> rtl/dtq_pkg.sv
// ----------------------------------------------------------------------------
// dtq_pkg
// Types and codes shared by the timer queue modules.
// ----------------------------------------------------------------------------
`default_nettype none
package dtq_pkg;
  localparam logic [1:0] KIND_POST = 2'd0;
  localparam logic [1:0] KIND_CANCEL_HANDLE = 2'd1;
  localparam logic [1:0] KIND_CANCEL_EVENT = 2'd2;
  localparam logic [1:0] KIND_TICK = 2'd3;

  localparam logic [2:0] RES_POSTED = 3'd0;
  localparam logic [2:0] RES_FIRED = 3'd1;
  localparam logic [2:0] RES_SUMMARY = 3'd2;
  localparam logic [2:0] RES_REMOVED = 3'd3;
  localparam logic [2:0] RES_FULL = 3'd4;

  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] now;
    logic [7:0]  event_id;
    logic [47:0] delay;
    logic [63:0] msg_data;
    logic [31:0] target_handle;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [31:0] handle;
    logic [7:0]  fired_event;
    logic [63:0] fired_data;
    logic [47:0] lateness;
    logic [47:0] next_wait;
    logic        queue_empty;
    logic [4:0]  removed_count;
    logic        last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input item
    logic scan_clear; // restart scan
    logic scan_step;  // examine one slot
    logic do_post;    // write post into found slot
    logic do_cancel;  // apply cancel mask
    logic do_fire;    // remove best, build fired result
    logic do_summary; // build summary result
    logic do_full;    // build full error result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       scan_done;
    logic       free_found;
    logic       best_found;
    logic       best_due;
    logic [1:0] kind;
  } dp_stat_t;
endpackage
`default_nettype wire

>>> rtl/dtq_stream_if.sv
// ----------------------------------------------------------------------------
// dtq_stream_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface dtq_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/dtq_datapath.sv
// ----------------------------------------------------------------------------
// dtq_datapath
// Entry store, one-slot-per-cycle scanner and result builder.
// ----------------------------------------------------------------------------
`default_nettype none
module dtq_datapath #(
  parameter int QUEUE_DEPTH = 16,
  parameter int EVENT_COUNT = 256
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dtq_pkg::in_item_t in_item,
  input  wire dtq_pkg::dp_cmd_t  cmd,
  output dtq_pkg::dp_stat_t      stat,
  output dtq_pkg::out_item_t     result
);
  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [QUEUE_DEPTH-1:0] valid;
  logic [63:0] dl_mem [QUEUE_DEPTH];
  logic [31:0] hd_mem [QUEUE_DEPTH];
  logic [7:0]  ev_mem [QUEUE_DEPTH];
  logic [63:0] da_mem [QUEUE_DEPTH];

  dtq_pkg::in_item_t item;
  dtq_pkg::out_item_t res_next;
  logic [31:0] next_handle;
  logic [CW-1:0] scan_idx;
  logic [IW-1:0] free_idx, best_idx;
  logic free_found, best_found;
  logic [63:0] best_dl;
  logic [31:0] best_hd;
  logic [QUEUE_DEPTH-1:0] hit_mask;
  logic [4:0] hit_cnt;
  logic [64:0] dl_sum;
  logic [63:0] dl_post;
  logic [7:0]  ev_fold;
  logic [7:0]  fold_lut [256];
  logic [IW-1:0] cur;
  logic cur_hit, better;
  logic [63:0] late_diff, wait_diff;

  assign cur = scan_idx[IW-1:0];
  assign dl_sum = {1'b0, item.now} + {17'd0, item.delay};
  assign dl_post = dl_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : dl_sum[63:0];

  // event id fold: constant lookup, one entry per 8-bit id
  generate
    for (genvar g = 0; g < 256; g++) begin : g_fold
      assign fold_lut[g] = 8'(g % EVENT_COUNT);
    end
  endgenerate
  assign ev_fold = fold_lut[item.event_id];

  assign cur_hit = valid[cur] && ((item.kind == dtq_pkg::KIND_CANCEL_HANDLE)
                   ? (hd_mem[cur] == item.target_handle) : (ev_mem[cur] == ev_fold));
  assign better = !best_found || (dl_mem[cur] < best_dl) ||
                  ((dl_mem[cur] == best_dl) && (hd_mem[cur] < best_hd));
  assign late_diff = item.now - best_dl;
  assign wait_diff = best_dl - item.now;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      next_handle <= '0;
      scan_idx <= '0;
      free_found <= 1'b0;
      best_found <= 1'b0;
      hit_cnt <= '0;
      hit_mask <= '0;
    end else begin
      if (cmd.load) item <= in_item;
      if (cmd.scan_clear) begin
        scan_idx <= '0;
        free_found <= 1'b0;
        best_found <= 1'b0;
        hit_cnt <= '0;
        hit_mask <= '0;
      end else if (cmd.scan_step) begin
        scan_idx <= scan_idx + 1'b1;
        if (!valid[cur] && !free_found) begin
          free_found <= 1'b1;
          free_idx <= cur;
        end
        if (valid[cur] && better) begin
          best_found <= 1'b1;
          best_idx <= cur;
          best_dl <= dl_mem[cur];
          best_hd <= hd_mem[cur];
        end
        if (cur_hit) begin
          hit_mask[cur] <= 1'b1;
          // count saturates at the field maximum
          if (hit_cnt != 5'd31) hit_cnt <= hit_cnt + 1'b1;
        end
      end
      if (cmd.do_post) begin
        valid[free_idx] <= 1'b1;
        dl_mem[free_idx] <= dl_post;
        hd_mem[free_idx] <= next_handle;
        ev_mem[free_idx] <= ev_fold;
        da_mem[free_idx] <= item.msg_data;
        next_handle <= next_handle + 1'b1;
      end
      if (cmd.do_cancel) valid <= valid & ~hit_mask;
      if (cmd.do_fire) valid[best_idx] <= 1'b0;
    end
  end

  always_comb begin
    res_next = result;
    if (cmd.do_post || cmd.do_full || cmd.do_cancel || cmd.do_fire || cmd.do_summary)
      res_next = '0;
    if (cmd.do_post) begin
      res_next.result_kind = dtq_pkg::RES_POSTED;
      res_next.handle = next_handle;
      res_next.last = 1'b1;
    end
    if (cmd.do_full) begin
      res_next.result_kind = dtq_pkg::RES_FULL;
      res_next.last = 1'b1;
    end
    if (cmd.do_cancel) begin
      res_next.result_kind = dtq_pkg::RES_REMOVED;
      res_next.removed_count = hit_cnt;
      res_next.queue_empty = ((valid & ~hit_mask) == '0);
      res_next.last = 1'b1;
    end
    if (cmd.do_fire) begin
      res_next.result_kind = dtq_pkg::RES_FIRED;
      res_next.handle = hd_mem[best_idx];
      res_next.fired_event = ev_mem[best_idx];
      res_next.fired_data = da_mem[best_idx];
      res_next.lateness = (late_diff[63:48] != '0) ? dtq_pkg::MAX48 : late_diff[47:0];
      res_next.queue_empty = ((valid & ~(QUEUE_DEPTH'(1) << best_idx)) == '0);
    end
    if (cmd.do_summary) begin
      res_next.result_kind = dtq_pkg::RES_SUMMARY;
      res_next.queue_empty = !best_found;
      res_next.next_wait = !best_found ? 48'd0 :
                           (wait_diff[63:48] != '0) ? dtq_pkg::MAX48 : wait_diff[47:0];
      res_next.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    result <= res_next;
  end

  always_comb begin
    stat.scan_done = (scan_idx == CW'(QUEUE_DEPTH));
    stat.free_found = free_found;
    stat.best_found = best_found;
    stat.best_due = best_dl <= item.now;
    stat.kind = item.kind;
  end
endmodule
`default_nettype wire

>>> rtl/dtq_ctrl.sv
// ----------------------------------------------------------------------------
// dtq_ctrl
// Sequencer: accept, scan, act, hand off one result at a time.
// ----------------------------------------------------------------------------
`default_nettype none
module dtq_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire logic             out_last,
  input  wire dtq_pkg::dp_stat_t stat,
  output dtq_pkg::dp_cmd_t      cmd
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_ACT = 3'd2;
  localparam logic [2:0] ST_OUT = 3'd3;

  logic [2:0] state, state_next;
  logic ov, ov_next;

  assign in_ready = (state == ST_IDLE) && !rst;
  assign out_valid = ov;

  always_comb begin
    state_next = state;
    ov_next = ov;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.scan_clear = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.scan_done) state_next = ST_ACT;
        else cmd.scan_step = 1'b1;
      end
      ST_ACT: begin
        ov_next = 1'b1;
        state_next = ST_OUT;
        case (stat.kind)
          dtq_pkg::KIND_POST: begin
            if (stat.free_found) cmd.do_post = 1'b1;
            else cmd.do_full = 1'b1;
          end
          dtq_pkg::KIND_TICK: begin
            if (stat.best_found && stat.best_due) cmd.do_fire = 1'b1;
            else cmd.do_summary = 1'b1;
          end
          default: cmd.do_cancel = 1'b1;
        endcase
      end
      ST_OUT: begin
        if (out_ready) begin
          ov_next = 1'b0;
          if (out_last) state_next = ST_IDLE;
          else begin
            cmd.scan_clear = 1'b1;
            state_next = ST_SCAN;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ov <= 1'b0;
    end else begin
      state <= state_next;
      ov <= ov_next;
    end
  end
endmodule
`default_nettype wire

>>> rtl/deadline_timer_event_queue_unit.sv
// ----------------------------------------------------------------------------
// deadline_timer_event_queue_unit
// Deadline-ordered timer message store with post, cancel and tick.
// ----------------------------------------------------------------------------
// Usage:
//  in_ch (sink): one operation per transfer: post, cancel by handle,
//    cancel by event or tick.
//  out_ch (source): result items; last marks the final result of an operation.
//  Every pass scans the store one slot per cycle. A post or cancel takes one
//  pass from transfer to result. A tick does one scan per
//  fired message plus one for the summary.
//  The next input is taken only after the last result transfers; the scan
//  over the slot store sets the rate.
//  Reset clears all slot valid bits and the handle counter.
//  When the receiver stalls, the result register holds and the sequencer
//  waits; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none
`include "deadline_timer_event_queue_unit_defines.svh"
module deadline_timer_event_queue_unit #(
  parameter int QUEUE_DEPTH = 16,
  parameter int EVENT_COUNT = 256
) (
  input wire logic clk,
  input wire logic rst,
  dtq_stream_if.sink   in_ch,
  dtq_stream_if.source out_ch
);
  dtq_pkg::dp_cmd_t  cmd;
  dtq_pkg::dp_stat_t stat;
  dtq_pkg::out_item_t result;

  // sequencer
  dtq_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_last(result.last), .stat(stat), .cmd(cmd)
  );

  // store and result builder
  dtq_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .EVENT_COUNT(EVENT_COUNT)) u_dp (
    .clk(clk), .rst(rst), .in_item(in_ch.data),
    .cmd(cmd), .stat(stat), .result(result)
  );

  assign out_ch.data = result;

  // no input taken while a result is pending
  `DTQ_ASSERT_IMPL(a_no_overlap, clk, rst, !(in_ch.ready && out_ch.valid))
  // an operation is captured only while the input is open
  `DTQ_ASSERT_IMPL(a_load_idle, clk, rst, cmd.load |-> in_ch.ready)
  // the summary always closes a tick
  `DTQ_ASSERT_IMPL(a_sum_last, clk, rst, cmd.do_summary |=> result.last)
endmodule
`default_nettype wire

>>> dv/dtq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_checker
// Watches the operation and result channels, keeps a shadow copy of the timer
// store and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module dtq_checker #(
  parameter int QUEUE_DEPTH = 16,
  parameter int EVENT_COUNT = 256
) (
  input  logic clk,
  input  logic rst,
  input  logic op_valid,
  input  logic op_ready,
  input  dtq_pkg::in_item_t op,
  input  logic res_valid,
  input  logic res_ready,
  input  dtq_pkg::out_item_t res,
  output int   errors,
  output int   pending
);
  logic        slot_used [QUEUE_DEPTH];
  logic [63:0] slot_deadline [QUEUE_DEPTH];
  logic [31:0] slot_handle [QUEUE_DEPTH];
  logic [7:0]  slot_event [QUEUE_DEPTH];
  logic [63:0] slot_data [QUEUE_DEPTH];
  logic [31:0] handle_ctr;
  dtq_pkg::out_item_t expected_results [$];

  assign pending = expected_results.size();

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic bit store_is_empty();
    foreach (slot_used[i]) if (slot_used[i]) return 0;
    return 1;
  endfunction

  function automatic int earliest_slot();
    int b;
    b = -1;
    foreach (slot_used[i]) begin
      if (!slot_used[i]) continue;
      if (b < 0 || slot_deadline[i] < slot_deadline[b] ||
          (slot_deadline[i] == slot_deadline[b] && slot_handle[i] < slot_handle[b]))
        b = i;
    end
    return b;
  endfunction

  function automatic logic [47:0] sat48(input logic [63:0] v);
    return (v > {16'd0, dtq_pkg::MAX48}) ? dtq_pkg::MAX48 : v[47:0];
  endfunction

  task automatic predict_operation(input dtq_pkg::in_item_t it);
    dtq_pkg::out_item_t r;
    int        slot, b, cnt;
    logic [7:0]  ev;
    logic [64:0] sum;
    ev = 8'((it.event_id) % EVENT_COUNT);
    r = '0;
    r.last = 1'b1;
    case (it.kind)
      dtq_pkg::KIND_POST: begin
        slot = -1;
        foreach (slot_used[i]) if (!slot_used[i] && slot < 0) slot = i;
        if (slot < 0) begin
          r.result_kind = dtq_pkg::RES_FULL;
        end else begin
          sum = {1'b0, it.now} + {17'd0, it.delay};
          slot_used[slot] = 1'b1;
          slot_deadline[slot] = sum[64] ? '1 : sum[63:0];
          slot_handle[slot] = handle_ctr;
          slot_event[slot] = ev;
          slot_data[slot] = it.msg_data;
          r.result_kind = dtq_pkg::RES_POSTED;
          r.handle = handle_ctr;
          handle_ctr++;
        end
        expected_results.push_back(r);
      end
      dtq_pkg::KIND_CANCEL_HANDLE, dtq_pkg::KIND_CANCEL_EVENT: begin
        cnt = 0;
        foreach (slot_used[i]) begin
          if (slot_used[i] && ((it.kind == dtq_pkg::KIND_CANCEL_HANDLE) ?
              slot_handle[i] == it.target_handle : slot_event[i] == ev)) begin
            slot_used[i] = 1'b0;
            cnt++;
          end
        end
        r.result_kind = dtq_pkg::RES_REMOVED;
        r.removed_count = 5'((cnt > 31) ? 31 : cnt);
        r.queue_empty = store_is_empty();
        expected_results.push_back(r);
      end
      default: begin
        // fire everything due, earliest deadline then lowest handle
        forever begin
          b = earliest_slot();
          if (b < 0 || slot_deadline[b] > it.now) break;
          slot_used[b] = 1'b0;
          r = '0;
          r.result_kind = dtq_pkg::RES_FIRED;
          r.handle = slot_handle[b];
          r.fired_event = slot_event[b];
          r.fired_data = slot_data[b];
          r.lateness = sat48(it.now - slot_deadline[b]);
          r.queue_empty = store_is_empty();
          expected_results.push_back(r);
        end
        r = '0;
        r.result_kind = dtq_pkg::RES_SUMMARY;
        r.last = 1'b1;
        b = earliest_slot();
        if (b < 0) r.queue_empty = 1'b1;
        else r.next_wait = sat48(slot_deadline[b] - it.now);
        expected_results.push_back(r);
      end
    endcase
  endtask

  task automatic compare_result(input dtq_pkg::out_item_t got);
    dtq_pkg::out_item_t w;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result", 64'(got.result_kind), 0);
      return;
    end
    w = expected_results.pop_front();
    if (got.result_kind !== w.result_kind)
      report_mismatch("result_kind", 64'(got.result_kind), 64'(w.result_kind));
    if (got.handle !== w.handle) report_mismatch("handle", 64'(got.handle), 64'(w.handle));
    if (got.fired_event !== w.fired_event)
      report_mismatch("fired_event", 64'(got.fired_event), 64'(w.fired_event));
    if (got.fired_data !== w.fired_data)
      report_mismatch("fired_data", got.fired_data, w.fired_data);
    if (got.lateness !== w.lateness)
      report_mismatch("lateness", 64'(got.lateness), 64'(w.lateness));
    if (got.next_wait !== w.next_wait)
      report_mismatch("next_wait", 64'(got.next_wait), 64'(w.next_wait));
    if (got.queue_empty !== w.queue_empty)
      report_mismatch("queue_empty", 64'(got.queue_empty), 64'(w.queue_empty));
    if (got.removed_count !== w.removed_count)
      report_mismatch("removed_count", 64'(got.removed_count), 64'(w.removed_count));
    if (got.last !== w.last) report_mismatch("last", 64'(got.last), 64'(w.last));
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    if (rst) begin
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      handle_ctr = '0;
      expected_results.delete();
    end else begin
      if (res_valid && res_ready) compare_result(res);
      if (op_valid && op_ready) predict_operation(op);
    end
  end
endmodule

>>> dv/tb_deadline_timer_event_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_deadline_timer_event_queue_unit
// Drives posts, cancels and ticks into the timer queue with random idling on
// both sides; the checker predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module tb_deadline_timer_event_queue_unit;
  localparam int QUEUE_DEPTH = 16;
  localparam int EVENT_COUNT = 256;
  // Longest stall: 17 tick passes, plus receiver hold-off.
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #1 clk = ~clk;

  dtq_stream_if #(.payload_t(dtq_pkg::in_item_t))  in_ch ();
  dtq_stream_if #(.payload_t(dtq_pkg::out_item_t)) out_ch ();

  deadline_timer_event_queue_unit #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .EVENT_COUNT(EVENT_COUNT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  int errors, pending;

  dtq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH), .EVENT_COUNT(EVENT_COUNT)) checker_i (
    .clk(clk), .rst(rst),
    .op_valid(in_ch.valid), .op_ready(in_ch.ready), .op(in_ch.data),
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res(out_ch.data),
    .errors(errors), .pending(pending)
  );

  // Idle percentages per phase; the last phase has no idling at all.
  int send_idle_pct = 35;
  int recv_idle_pct = 83;
  bit hold_off = 0;      // receiver long stall request
  logic [63:0] clock_ns; // running notion of "now" for the stimulus
  logic [31:0] handle_guess;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // Receiver: random ready, forced low during a hold-off stretch.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        for (n = 0; n < 400; n++) @(negedge clk);
        hold_off = 0;
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // One operation transfer, with optional idle cycles before it; valid stays
  // up afterwards so the next call or the caller decides what follows.
  task automatic send_op(input dtq_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic dtq_pkg::in_item_t make_op(input logic [1:0] k);
    dtq_pkg::in_item_t it;
    it = '0;
    it.kind = k;
    it.now = clock_ns;
    it.event_id = 8'($urandom_range(7));
    it.delay = 48'($urandom_range(200));
    it.msg_data = {$urandom, $urandom};
    it.target_handle = handle_guess - 32'($urandom_range(20));
    return it;
  endfunction

  // Random op mix: mostly posts and ticks with time moving forward, plus noise.
  task automatic random_op();
    dtq_pkg::in_item_t it;
    logic [223:0] noise;
    int sel;
    sel = $urandom_range(99);
    if (sel < 8) begin
      // full-range noise
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      it = noise[$bits(dtq_pkg::in_item_t)-1:0];
    end else begin
      clock_ns += 64'($urandom_range(60));
      if (sel < 55) it = make_op(dtq_pkg::KIND_POST);
      else if (sel < 70) it = make_op(dtq_pkg::KIND_CANCEL_HANDLE);
      else if (sel < 78) it = make_op(dtq_pkg::KIND_CANCEL_EVENT);
      else it = make_op(dtq_pkg::KIND_TICK);
      if (sel < 12) it.delay = 48'({$urandom, $urandom});
    end
    if (it.kind == dtq_pkg::KIND_POST) handle_guess++;
    send_op(it);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  int idle_cycles;
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || rst)
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("deadline_timer_event_queue_unit verification failed");
        $finish;
      end
    end
  end

  initial begin
    dtq_pkg::in_item_t it;
    int i;
    clock_ns = 64'd1000;
    handle_guess = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty tick, extremes, saturation, full store, cancels.
    it = make_op(dtq_pkg::KIND_TICK); send_op(it);
    it = make_op(dtq_pkg::KIND_POST); it.now = '1; it.delay = '1; it.event_id = 8'hFF;
    it.msg_data = '1; send_op(it);
    it = make_op(dtq_pkg::KIND_POST); it.now = '0; it.delay = '1; it.event_id = 8'h00;
    it.msg_data = '0; send_op(it);
    it = make_op(dtq_pkg::KIND_TICK); it.now = '0; send_op(it); // next_wait saturates
    for (i = 0; i < 15; i++) begin
      it = make_op(dtq_pkg::KIND_POST); it.delay = 48'd5; it.event_id = 8'(i % 3);
      send_op(it);
    end
    it = make_op(dtq_pkg::KIND_POST); send_op(it); // store full
    it = make_op(dtq_pkg::KIND_CANCEL_EVENT); it.event_id = 8'd1; send_op(it);
    it = make_op(dtq_pkg::KIND_CANCEL_HANDLE); it.target_handle = 32'd0; send_op(it);
    it = make_op(dtq_pkg::KIND_CANCEL_HANDLE); it.target_handle = '1; send_op(it);
    // everything fires, lateness saturates
    it = make_op(dtq_pkg::KIND_TICK); it.now = '1; send_op(it);
    handle_guess = 32'd17;
    wait_drained();

    // Pressure: receiver holds off while random operations keep coming.
    hold_off = 1;
    for (i = 0; i < 6; i++) random_op();

    for (i = 0; i < 210; i++) begin
      if (i == 70) begin send_idle_pct = 83; recv_idle_pct = 35; end
      if (i == 140) begin send_idle_pct = 0; recv_idle_pct = 0; end
      random_op();
    end

    it = make_op(dtq_pkg::KIND_TICK); it.now = '1; send_op(it);
    wait_drained();
    repeat (QUEUE_DEPTH * 4) @(negedge clk);
    if (errors == 0 && pending == 0)
      $display("deadline_timer_event_queue_unit verification clean");
    else
      $display("deadline_timer_event_queue_unit verification failed");
    $finish;
  end
endmodule

>>> files.f
+incdir+rtl
rtl/dtq_pkg.sv
rtl/dtq_stream_if.sv
rtl/dtq_datapath.sv
rtl/dtq_ctrl.sv
rtl/deadline_timer_event_queue_unit.sv
dv/dtq_checker.sv
dv/tb_deadline_timer_event_queue_unit.sv
